// ----- hdl/bipartite_graph_check_macros.svh -----
// Assertion macros shared by the bipartite graph check RTL.
// Expects signals named clk and rst in the scope of each use.
`ifndef BIPARTITE_GRAPH_CHECK_MACROS_SVH
`define BIPARTITE_GRAPH_CHECK_MACROS_SVH

// Checked outside reset only.
`define BGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define BGC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/bgc_pkg.sv -----
// Shared types and constants of the bipartite graph check.
// No dependencies.
package bgc_pkg;

  localparam int MAX_NODES_DEF = 256;
  localparam int MAX_EDGES_DEF = 1024;
  localparam int NODE_W        = 8;
  localparam int CNT_W         = 9;
  localparam int DATA_W        = 32;
  localparam int ADDR_W        = 3;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(1);
  localparam logic             REG_NODE_COUNT = 1'b0;

  typedef enum logic [1:0] {
    COL_NONE = 2'd0,
    COL_RED  = 2'd1,
    COL_BLUE = 2'd2
  } colour_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ROOT,
    S_ROOT_CHK,
    S_FETCH,
    S_EDGE,
    S_COL,
    S_LIST,
    S_POP,
    S_POP_RD,
    S_POP_LD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic root_next;
    logic root_push;
    logic list_ld;
    logic fetch;
    logic edge_chk;
    logic push;
    logic fail;
    logic pop;
    logic pop_rd;
    logic pop_ld;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic root_done;
    logic root_coloured;
    logic top_exhausted;
    logic tgt_out;
    logic tgt_uncoloured;
    logic tgt_conflict;
    logic depth_one;
  } status_t;

endpackage

// ----- hdl/bgc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/bgc_ctrl.sv -----
// Controller of the bipartite graph check: sequences clear, load and walk.
// Depends on bgc_pkg.
module bgc_ctrl
  import bgc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    last,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:    if (status.clr_last) state_next = S_IDLE;
      S_IDLE:     if (start && last) state_next = S_ROOT;
      S_ROOT:     state_next = status.root_done ? S_DONE : S_ROOT_CHK;
      S_ROOT_CHK: state_next = status.root_coloured ? S_ROOT : S_LIST;
      S_LIST:     state_next = S_FETCH;
      S_FETCH:    state_next = status.top_exhausted ? S_POP : S_EDGE;
      S_EDGE:     state_next = status.tgt_out ? S_FETCH : S_COL;
      S_COL: begin
        if (status.tgt_uncoloured) state_next = S_LIST;
        else if (status.tgt_conflict) state_next = S_DONE;
        else state_next = S_FETCH;
      end
      S_POP:      state_next = status.depth_one ? S_ROOT : S_POP_RD;
      S_POP_RD:   state_next = S_POP_LD;
      S_POP_LD:   state_next = S_FETCH;
      S_DONE:     state_next = S_CLEAR;
      default:    state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      S_CLEAR: cmd.clr = 1'b1;
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_ROOT:     cmd = '0;
      S_ROOT_CHK: begin
        cmd.root_next = status.root_coloured;
        cmd.root_push = !status.root_coloured;
      end
      S_LIST:  cmd.list_ld = 1'b1;
      S_FETCH: cmd.fetch = !status.top_exhausted;
      S_EDGE:  cmd.edge_chk = !status.tgt_out;
      S_COL: begin
        cmd.push = status.tgt_uncoloured;
        cmd.fail = !status.tgt_uncoloured && status.tgt_conflict;
      end
      S_POP: begin
        cmd.pop       = !status.depth_one;
        cmd.root_next = status.depth_one;
      end
      S_POP_RD: cmd.pop_rd = 1'b1;
      S_POP_LD: cmd.pop_ld = 1'b1;
      S_DONE:   cmd.finish = 1'b1;
      default:  cmd = '0;
    endcase
  end

endmodule

// ----- hdl/bgc_dp.sv -----
// Datapath of the bipartite graph check: adjacency stores, colours, walk stack.
// Depends on bgc_pkg and bgc_ram.
module bgc_dp
  import bgc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic [CNT_W-1:0]  node_count,
  input  logic [NODE_W-1:0] source_node,
  input  logic [NODE_W-1:0] target_node,
  input  logic              has_edge,
  input  logic              last,
  output status_t           status,
  output logic              result_valid,
  output logic              is_bipartite,
  output logic              edges_dropped
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int EA  = $clog2(MAX_EDGES);
  localparam int FW  = $clog2(MAX_EDGES + 1);

  logic [NCW-1:0]    n_eff;
  logic [FW-1:0]     fill;
  logic              drop;
  logic [NODE_W-1:0] prev_src;
  logic              prev_valid;
  logic [EA-1:0]     cur_start;
  logic [FW-1:0]     cur_len;
  logic              pass;
  logic [NCW-1:0]    root;
  logic [NCW-1:0]    depth;
  logic [FW-1:0]     top_off;
  colour_t           top_col;
  logic [EA-1:0]     top_start;
  logic [FW-1:0]     top_len;
  logic [NODE_W-1:0] tgt;
  logic [NW-1:0]     clr_addr;

  logic              edge_bad;
  logic              same_src;
  logic              load_ok;
  logic [FW-1:0]     new_len;
  logic [EA-1:0]     new_start;
  colour_t           want;

  // RAM ports
  logic              edge_we;
  logic [EA-1:0]     edge_raddr;
  logic [NODE_W-1:0] edge_rdata;
  logic              list_we;
  logic [NW-1:0]     list_waddr;
  logic [EA-1:0]     start_wdata;
  logic [FW-1:0]     len_wdata;
  logic [NW-1:0]     list_raddr;
  logic [EA-1:0]     start_rdata;
  logic [FW-1:0]     len_rdata;
  logic              col_we;
  logic [NW-1:0]     col_waddr;
  logic [1:0]        col_wdata;
  logic [NW-1:0]     col_raddr;
  logic [1:0]        col_rdata;
  logic              snode_we;
  logic [NW-1:0]     snode_waddr;
  logic [NW-1:0]     snode_wdata;
  logic [NW-1:0]     stk_raddr;
  logic [NW-1:0]     snode_rdata;
  logic [FW-1:0]     soff_rdata;

  always_comb begin
    if (node_count == '0) begin
      n_eff = NCW'(1);
    end else if (32'(node_count) > MAX_NODES) begin
      n_eff = NCW'(MAX_NODES);
    end else begin
      n_eff = NCW'(node_count);
    end
  end

  assign edge_bad = (32'(source_node) >= 32'(n_eff)) || (32'(target_node) >= 32'(n_eff)) ||
                    (prev_valid && (source_node < prev_src)) || (32'(fill) >= MAX_EDGES);
  assign same_src  = prev_valid && (source_node == prev_src);
  assign load_ok   = cmd.load && has_edge && !edge_bad;
  assign new_len   = same_src ? FW'(cur_len + FW'(1)) : FW'(1);
  assign new_start = same_src ? cur_start : EA'(fill);
  assign want      = (top_col == COL_RED) ? COL_BLUE : COL_RED;

  // Status back to the controller
  always_comb begin
    status.clr_last       = (clr_addr == NW'(MAX_NODES - 1));
    status.root_done      = (root >= n_eff);
    status.root_coloured  = (col_rdata != COL_NONE);
    status.top_exhausted  = (top_off >= top_len);
    status.tgt_out        = (32'(edge_rdata) >= 32'(n_eff));
    status.tgt_uncoloured = (col_rdata == COL_NONE);
    status.tgt_conflict   = (col_rdata != want);
    status.depth_one      = (depth == NCW'(1));
  end

  // RAM port selection
  assign edge_we    = load_ok;
  assign edge_raddr = EA'(FW'(top_start) + top_off);

  always_comb begin
    list_we     = load_ok || cmd.clr;
    list_waddr  = cmd.clr ? clr_addr : NW'(source_node);
    len_wdata   = cmd.clr ? '0 : new_len;
    start_wdata = new_start;
    if (cmd.pop_rd) begin
      list_raddr = snode_rdata;
    end else if (cmd.push) begin
      list_raddr = NW'(tgt);
    end else begin
      list_raddr = NW'(root);
    end
  end

  always_comb begin
    col_we    = cmd.clr || cmd.root_push || cmd.push;
    col_waddr = NW'(root);
    col_wdata = COL_RED;
    if (cmd.clr) begin
      col_waddr = clr_addr;
      col_wdata = COL_NONE;
    end else if (cmd.push) begin
      col_waddr = NW'(tgt);
      col_wdata = want;
    end
    if (cmd.edge_chk) begin
      col_raddr = NW'(edge_rdata);
    end else if (cmd.pop_rd) begin
      col_raddr = snode_rdata;
    end else begin
      col_raddr = NW'(root);
    end
  end

  assign snode_we    = cmd.root_push || cmd.push;
  assign snode_waddr = cmd.push ? NW'(depth) : '0;
  assign snode_wdata = cmd.push ? NW'(tgt) : NW'(root);
  assign stk_raddr   = NW'(depth - NCW'(2));

  bgc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(EA'(fill)), .wdata(target_node),
    .raddr(edge_raddr), .rdata(edge_rdata)
  );

  bgc_ram #(.WIDTH(EA), .DEPTH(MAX_NODES)) u_start_ram (
    .clk(clk), .we(load_ok), .waddr(list_waddr), .wdata(start_wdata),
    .raddr(list_raddr), .rdata(start_rdata)
  );

  bgc_ram #(.WIDTH(FW), .DEPTH(MAX_NODES)) u_len_ram (
    .clk(clk), .we(list_we), .waddr(list_waddr), .wdata(len_wdata),
    .raddr(list_raddr), .rdata(len_rdata)
  );

  bgc_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_colour_ram (
    .clk(clk), .we(col_we), .waddr(col_waddr), .wdata(col_wdata),
    .raddr(col_raddr), .rdata(col_rdata)
  );

  bgc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_stack_node_ram (
    .clk(clk), .we(snode_we), .waddr(snode_waddr), .wdata(snode_wdata),
    .raddr(stk_raddr), .rdata(snode_rdata)
  );

  // Cursor of the parent is saved when a child goes on top of it
  bgc_ram #(.WIDTH(FW), .DEPTH(MAX_NODES)) u_stack_off_ram (
    .clk(clk), .we(cmd.push), .waddr(NW'(depth - NCW'(1))), .wdata(top_off),
    .raddr(stk_raddr), .rdata(soff_rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      drop         <= 1'b0;
      prev_valid   <= 1'b0;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.finish;
      if (cmd.clr) begin
        clr_addr <= NW'(clr_addr + NW'(1));
      end
      if (cmd.load && has_edge) begin
        if (edge_bad) begin
          drop <= 1'b1;
        end else begin
          fill       <= FW'(fill + FW'(1));
          prev_valid <= 1'b1;
        end
      end
      if (cmd.finish) begin
        fill       <= '0;
        drop       <= 1'b0;
        prev_valid <= 1'b0;
        clr_addr   <= '0;
      end
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    if (load_ok) begin
      prev_src  <= source_node;
      cur_start <= new_start;
      cur_len   <= new_len;
    end
    if (cmd.load && last) begin
      root <= '0;
      pass <= 1'b1;
    end
    if (cmd.root_next) begin
      root <= NCW'(root + NCW'(1));
    end
    if (cmd.root_push) begin
      depth   <= NCW'(1);
      top_off <= '0;
      top_col <= COL_RED;
    end
    if (cmd.list_ld || cmd.pop_ld) begin
      top_start <= start_rdata;
      top_len   <= len_rdata;
    end
    if (cmd.pop_ld) begin
      top_col <= colour_t'(col_rdata);
    end
    if (cmd.fetch) begin
      top_off <= FW'(top_off + FW'(1));
    end
    if (cmd.edge_chk) begin
      tgt <= edge_rdata;
    end
    if (cmd.push) begin
      depth   <= NCW'(depth + NCW'(1));
      top_off <= '0;
      top_col <= want;
    end
    if (cmd.fail) begin
      pass <= 1'b0;
    end
    if (cmd.pop) begin
      depth <= NCW'(depth - NCW'(1));
    end
    if (cmd.pop_rd) begin
      top_off <= soff_rdata;
    end
    if (cmd.finish) begin
      is_bipartite  <= pass;
      edges_dropped <= drop;
    end
  end

endmodule

// ----- hdl/bipartite_graph_check.sv -----
// Top level of the bipartite graph check: register port, controller, datapath.
// Depends on bgc_pkg, bgc_ctrl, bgc_dp and bipartite_graph_check_macros.svh.
//
//  channel   handshake                         payload
//  -------   -------------------------------   ---------------------------------------
//  config    psel/penable/pwrite, pready = 1    paddr, pwdata -> node_count; prdata
//  request   start && !busy                     source_node, target_node, has_edge, last
//  result    result_valid, one cycle            is_bipartite, edges_dropped
//
// Edge requests are taken one per cycle while idle. A request with last set
// starts the two-colour walk through each root, each edge followed and each
// stack pop in turn, as each store has a single read port.
// After each result, and after reset, a clearing pass over all MAX_NODES entries
// wipes list lengths and colours; busy stays high throughout.
// The result strobe lasts one cycle and cannot be stalled.
`include "bipartite_graph_check_macros.svh"

module bipartite_graph_check
  import bgc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  logic [NODE_W-1:0] source_node,
  input  logic [NODE_W-1:0] target_node,
  input  logic              has_edge,
  input  logic              last,
  output logic              result_valid,
  output logic              is_bipartite,
  output logic              edges_dropped
);

  logic [CNT_W-1:0] node_count;
  cmd_t             cmd;
  status_t          status;

  // Register port: node count at word zero, nothing else decoded
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NODE_COUNT) ? DATA_W'(node_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_NODE_COUNT)) begin
      node_count <= pwdata[CNT_W-1:0];
    end
  end

  bgc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .last(last),
    .status(status), .cmd(cmd), .busy(busy)
  );

  bgc_dp #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .node_count(node_count),
    .source_node(source_node), .target_node(target_node),
    .has_edge(has_edge), .last(last), .status(status),
    .result_valid(result_valid), .is_bipartite(is_bipartite),
    .edges_dropped(edges_dropped)
  );

  // A result only appears while the block is still busy with its check
  `BGC_ASSERT(a_result_busy, result_valid |-> busy, "result outside a check")
  // A closing request always starts a check
  `BGC_ASSERT(a_last_busy, (start && !busy && last) |=> busy, "last request did not start check")
  // One strobe per check
  `BGC_ASSERT(a_single_result, result_valid |=> !result_valid, "result repeated")
  // Reset drops any pending result
  `BGC_ASSERT_ALWAYS(a_reset_quiet, rst |=> !result_valid, "result after reset")

endmodule

// ----- sim/bgc_checker.sv -----
`timescale 1ns / 100ps
// Checker for the bipartite graph check: tracks node_count writes and edge requests,
// predicts each verdict and compares it with the result strobe. Depends on bgc_pkg.
module bgc_checker
  import bgc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              start,
  input  logic              busy,
  input  logic [NODE_W-1:0] source_node,
  input  logic [NODE_W-1:0] target_node,
  input  logic              has_edge,
  input  logic              last,
  input  logic              result_valid,
  input  logic              is_bipartite,
  input  logic              edges_dropped,
  output int                errors,
  output int                pending,
  output int                graphs_seen,
  output int                graphs_bipartite
);

  localparam int NMAX = MAX_NODES_DEF;
  localparam int EMAX = MAX_EDGES_DEF;

  typedef struct packed {
    logic bip;
    logic drop;
  } verdict_t;

  verdict_t        verdict_q[$];
  logic [7:0]      tgt_mem[EMAX];
  int              lst_start[NMAX];
  int              lst_len[NMAX];
  colour_t         colour[NMAX];
  int              stk_node[NMAX];
  int              stk_cur[NMAX];
  int              fill;
  bit              dropped;
  int              prev_src;
  bit              prev_ok;
  logic [CNT_W-1:0] cnt_reg;

  function automatic int eff_nodes();
    int n;
    n = cnt_reg;
    if (n == 0) n = 1;
    if (n > NMAX) n = NMAX;
    return n;
  endfunction

  task automatic clear_lists();
    for (int i = 0; i < NMAX; i++) begin
      lst_start[i] = 0;
      lst_len[i] = 0;
    end
    fill = 0;
    dropped = 0;
    prev_src = 0;
    prev_ok = 0;
  endtask

  task automatic add_edge(int src, int dst, int n);
    if (src >= n || dst >= n || (prev_ok && src < prev_src) || fill >= EMAX) begin
      dropped = 1;
    end else begin
      if (lst_len[src] == 0) lst_start[src] = fill;
      tgt_mem[fill] = dst[7:0];
      fill++;
      lst_len[src]++;
      prev_src = src;
      prev_ok = 1;
    end
  endtask

  // Depth-first two-colouring with an explicit stack, roots in index order.
  function automatic logic two_colour_ok(int n);
    int depth, top, u, k, fin, t;
    colour_t want;
    for (int i = 0; i < NMAX; i++) colour[i] = COL_NONE;
    for (int root = 0; root < n; root++) begin
      if (colour[root] != COL_NONE) continue;
      colour[root] = COL_RED;
      stk_node[0] = root;
      stk_cur[0] = lst_start[root];
      depth = 1;
      while (depth > 0) begin
        top = depth - 1;
        u = stk_node[top];
        k = stk_cur[top];
        fin = lst_start[u] + lst_len[u];
        if (k >= fin || k >= EMAX) begin
          depth--;
          continue;
        end
        stk_cur[top] = k + 1;
        t = tgt_mem[k];
        if (t >= n) continue;
        want = (colour[u] == COL_RED) ? COL_BLUE : COL_RED;
        if (colour[t] == COL_NONE) begin
          if (depth >= NMAX) return 1'b0;
          colour[t] = want;
          stk_node[depth] = t;
          stk_cur[depth] = lst_start[t];
          depth++;
        end else if (colour[t] != want) begin
          return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    verdict_t v;
    if (rst) begin
      clear_lists();
      cnt_reg = NODE_COUNT_RST;
      verdict_q.delete();
      errors = 0;
      graphs_seen = 0;
      graphs_bipartite = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_NODE_COUNT, 2'b00})
        cnt_reg = pwdata[CNT_W-1:0];
      if (result_valid) begin
        if (verdict_q.size() == 0) begin
          $error("result with no verdict waiting: is_bipartite=%0b edges_dropped=%0b",
                 is_bipartite, edges_dropped);
          errors++;
        end else begin
          v = verdict_q.pop_front();
          if (is_bipartite !== v.bip) begin
            $error("is_bipartite: expected %0b, got %0b", v.bip, is_bipartite);
            errors++;
          end
          if (edges_dropped !== v.drop) begin
            $error("edges_dropped: expected %0b, got %0b", v.drop, edges_dropped);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        if (has_edge) add_edge(source_node, target_node, eff_nodes());
        if (last) begin
          v.bip = two_colour_ok(eff_nodes());
          v.drop = dropped;
          verdict_q.push_back(v);
          graphs_seen++;
          if (v.bip) graphs_bipartite++;
          clear_lists();
        end
      end
    end
    pending = verdict_q.size();
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Top of the bipartite graph check testbench: clock, reset, node_count writes and
// graph requests. Depends on bgc_pkg, bgc_checker and the bipartite_graph_check RTL.
module tb;
  import bgc_pkg::*;

  logic              clk;
  logic              rst;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic              start, busy;
  logic [NODE_W-1:0] source_node, target_node;
  logic              has_edge, last;
  logic              result_valid, is_bipartite, edges_dropped;
  int                errors, pending, graphs_seen, graphs_bipartite;

  // Test state: current node count, sender idle rate, requests sent
  int                cur_nodes;
  int                idle_pct;
  int                sent;

  bipartite_graph_check dut (.*);

  bgc_checker chk (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .pready(pready), .paddr(paddr), .pwdata(pwdata), .start(start), .busy(busy),
    .source_node(source_node), .target_node(target_node), .has_edge(has_edge),
    .last(last), .result_valid(result_valid), .is_bipartite(is_bipartite),
    .edges_dropped(edges_dropped), .errors(errors), .pending(pending),
    .graphs_seen(graphs_seen), .graphs_bipartite(graphs_bipartite)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: far beyond the slowest correct run
  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Hold until every verdict has arrived and the clearing pass is over
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (MAX_NODES_DEF + 40) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  // Write node_count; upper data bits are random since the block ignores them
  task automatic set_nodes(int value);
    drain();
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {REG_NODE_COUNT, 2'b00};
    pwdata = {$urandom} << CNT_W | DATA_W'(value[CNT_W-1:0]);
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    cur_nodes = value == 0 ? 1 : (value > MAX_NODES_DEF ? MAX_NODES_DEF : value);
  endtask

  // Present one request from a falling edge and hold it until taken
  task automatic send(int src, int dst, bit he, bit fin);
    bit was_busy;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start = 1'b1;
    source_node = src[NODE_W-1:0];
    target_node = dst[NODE_W-1:0];
    has_edge = he;
    last = fin;
    do begin
      was_busy = busy;
      @(posedge clk);
      @(negedge clk);
    end while (was_busy);
    start = 1'b0;
    sent++;
  endtask

  // Drive one graph grouped by source; most targets sit on the opposite side
  // of a hidden partition, so many graphs pass. Occasionally inject noise,
  // out-of-range and out-of-order edges.
  task automatic send_graph(int density, int bad_pct, int max_deg);
    bit side[MAX_NODES_DEF];
    int deg, dst, n_sent;
    n_sent = 0;
    for (int i = 0; i < cur_nodes; i++) side[i] = $urandom_range(1);
    for (int s = 0; s < cur_nodes; s++) begin
      if ($urandom_range(99) >= density) continue;
      deg = $urandom_range(1, max_deg);
      for (int e = 0; e < deg; e++) begin
        dst = $urandom_range(cur_nodes - 1);
        for (int r = 0; r < 4 && side[dst] == side[s]; r++)
          dst = $urandom_range(cur_nodes - 1);
        if ($urandom_range(99) < 5) send($urandom, $urandom, 1'b0, 1'b0);
        if ($urandom_range(99) < bad_pct) begin
          case ($urandom_range(2))
            0: send($urandom_range(255), dst, 1'b1, 1'b0);
            1: send(s, $urandom_range(255), 1'b1, 1'b0);
            default: send(s == 0 ? 0 : $urandom_range(s - 1), dst, 1'b1, 1'b0);
          endcase
        end else begin
          send(s, dst, 1'b1, 1'b0);
        end
        n_sent++;
      end
    end
    // Close with an edge on the final node or with an empty item
    if ($urandom_range(1)) send(cur_nodes - 1, $urandom_range(cur_nodes - 1), 1'b1, 1'b1);
    else send($urandom, $urandom, 1'b0, 1'b1);
  endtask

  initial begin
    int phase;
    int counts[6];
    counts = '{2, 5, 9, 16, 3, 12};
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    start = 1'b0; source_node = '0; target_node = '0; has_edge = 1'b0; last = 1'b0;
    cur_nodes = 1;
    idle_pct = 0;
    sent = 0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Directed: single node with a self loop (conflict), zero count acting as one
    send(0, 0, 1'b1, 1'b1);
    set_nodes(0);
    send(0, 0, 1'b0, 1'b1);
    // Triangle fails, square passes
    set_nodes(4);
    send(0, 1, 1'b1, 1'b0); send(1, 2, 1'b1, 1'b0); send(2, 0, 1'b1, 1'b1);
    send(0, 1, 1'b1, 1'b0); send(1, 2, 1'b1, 1'b0); send(2, 3, 1'b1, 1'b0);
    send(3, 0, 1'b1, 1'b1);
    // Full range of node indices, count above the maximum clamps
    set_nodes(511);
    send(0, 255, 1'b1, 1'b0); send(255, 0, 1'b1, 1'b0); send(255, 170, 1'b1, 1'b1);
    // Noise item is ignored; out-of-order and out-of-range edges are dropped
    set_nodes(8);
    send(85, 170, 1'b0, 1'b0);
    send(5, 1, 1'b1, 1'b0); send(3, 2, 1'b1, 1'b0); send(6, 9, 1'b1, 1'b0);
    send(7, 7, 1'b1, 1'b1);
    // Lower the count after loading: edges to dropped nodes are skipped
    send(0, 1, 1'b1, 1'b0); send(1, 6, 1'b1, 1'b0); send(6, 1, 1'b1, 1'b0);
    set_nodes(4);
    send(1, 0, 1'b1, 1'b1);
    set_nodes(256);
    send(0, 1, 1'b1, 1'b1);

    // Random graphs, cycling through the idle phases
    phase = 0;
    while (sent < 800) begin
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 57;
        default: idle_pct = 37;
      endcase
      if (phase % 7 == 6) set_nodes($urandom_range(1) ? 256 : 200);
      else if (phase % 5 == 4) set_nodes($urandom_range(1) ? 1 : 300);
      else set_nodes(counts[$urandom_range(5)] + $urandom_range(3));
      for (int g = 0; g < 4 && sent < 800; g++) begin
        if (cur_nodes > 32) send_graph(4, 3, 2);
        else send_graph(60, 8, 3);
      end
      phase++;
    end

    // Overflow the edge store once, with no idling
    idle_pct = 0;
    set_nodes(8);
    for (int i = 0; i < MAX_EDGES_DEF + 6; i++)
      send(i * 8 / (MAX_EDGES_DEF + 6), $urandom_range(7), 1'b1, 1'b0);
    send(7, 0, 1'b1, 1'b1);

    drain();
    $display("Covered %0d requests forming %0d graphs; %0d two-colourable.",
             sent, graphs_seen, graphs_bipartite);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
